// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the indexed min-heap.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/imh_pkg.sv -----
// Package for the indexed min-heap: payload structs, codes and sequencer states.
// Depends on nothing.
package imh_pkg;

  localparam int unsigned IdWidth    = 12;
  localparam int unsigned KeyFieldW  = 32;
  localparam int unsigned CountWidth = 13;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_UPDATE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_IGNORED  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOT_OPEN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    NODE_UNSEEN = 2'd0,
    NODE_OPEN   = 2'd1,
    NODE_CLOSED = 2'd2
  } node_state_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [IdWidth-1:0]   node_id;
    logic [KeyFieldW-1:0] key_primary;
    logic [KeyFieldW-1:0] key_secondary;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [IdWidth-1:0]    popped_node;
    logic [KeyFieldW-1:0]  popped_key_primary;
    logic [KeyFieldW-1:0]  popped_key_secondary;
    logic [IdWidth-1:0]    top_node;
    logic                  top_valid;
    logic [CountWidth-1:0] entry_count;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,        // status read
    S_CHK_W,
    S_POP_RD,     // read slot0
    S_POP_K,
    S_POS_RD,     // read node_position
    S_RM_RD,      // read last slot
    S_RM_WR,
    S_UPD_WR,
    S_RP_RDP,     // repair: read slot at parent
    S_RP_RDK,     // read key of parent node
    S_RP_CMP,
    S_SD_RDL,     // sift down: read left slot
    S_SD_RDR,
    S_SD_KL,
    S_SD_KR,
    S_SD_SEL,
    S_SWAP,
    S_TOP_RD,
    S_TOP_W,
    S_DONE
  } seq_e;

endpackage

// ----- hw/rtl/imh_key_cmp.sv -----
// Shared two-part key comparator, registered result (strict lexicographic less).
// Depends on nothing.
module imh_key_cmp #(
  parameter int unsigned KeyW = 32
) (
  input  logic              clk_i,
  input  logic [2*KeyW-1:0] a_i,
  input  logic [2*KeyW-1:0] b_i,
  output logic              less_o
);
  logic less_q;

  always_ff @(posedge clk_i) begin
    less_q <= (a_i < b_i);
  end

  assign less_o = less_q;
endmodule

// ----- hw/rtl/imh_mem.sv -----
// Single-port synchronous memory with registered read data.
// Depends on nothing.
module imh_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hw/rtl/indexed_min_heap_two_key.sv -----
// Indexed binary min-heap over node ids with two-part keys: insert, pop, delete and
// update, one command at a time. busy stays high while a command runs; the result
// is shown for exactly one cycle with done_o, and the receiver cannot hold it off.
// A command runs its setup steps and the parent compare of a delete or update, then
// sifts up or down level by level (up to log2(NODE_COUNT) levels), makes a last
// compare and reads the top; done_o follows. The pace of these steps is set by the
// single-port slot, position and key memories that each sift step reads and writes
// in turn. After reset a clearing pass over all NODE_COUNT entries resets node
// status; busy is high meanwhile.
// Depends on imh_pkg, imh_mem, imh_key_cmp and assert_macros.svh.
`include "assert_macros.svh"
module indexed_min_heap_two_key #(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned KEY_WIDTH  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  imh_pkg::cmd_t cmd_i,
  output logic          done_o,
  output imh_pkg::rsp_t rsp_o
);
  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned KW = 2 * KEY_WIDTH;
  localparam int unsigned IdW = imh_pkg::IdWidth;

  imh_pkg::seq_e st_q, st_d;
  logic clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  imh_pkg::cmd_t cmd_q, cmd_d;
  logic [CW-1:0] size_q, size_d;
  logic [AW-1:0] pos_q, pos_d;       // current position being repaired
  logic [AW-1:0] oth_q, oth_d;       // parent or chosen child
  logic [AW-1:0] nid_q, nid_d;       // node at pos
  logic [AW-1:0] onid_q, onid_d;     // node at oth
  logic [AW-1:0] lnid_q, lnid_d;
  logic [KW-1:0] key_q, key_d;       // key of node at pos
  logic [KW-1:0] okey_q, okey_d;
  logic [KW-1:0] lkey_q, lkey_d;
  logic          up_q, up_d;         // sifting upward
  logic          hasr_q, hasr_d;
  logic          swp_q, swp_d;       // swap phase
  imh_pkg::rsp_t rsp_q, rsp_d;
  logic          done_q, done_d;

  // memories
  logic          sl_we, ps_we, ky_we, ns_we;
  logic [AW-1:0] sl_a, ps_a, ky_a, ns_a;
  logic [AW-1:0] sl_wd, ps_wd, sl_rd, ps_rd;
  logic [KW-1:0] ky_wd, ky_rd;
  logic [1:0]    ns_wd, ns_rd;
  logic          less;
  logic [KW-1:0] cmp_a, cmp_b;

  imh_mem #(.Depth(NODE_COUNT), .Width(AW)) u_slots (
    .clk_i, .we_i(sl_we), .addr_i(sl_a), .wdata_i(sl_wd), .rdata_o(sl_rd));
  imh_mem #(.Depth(NODE_COUNT), .Width(AW)) u_pos (
    .clk_i, .we_i(ps_we), .addr_i(ps_a), .wdata_i(ps_wd), .rdata_o(ps_rd));
  imh_mem #(.Depth(NODE_COUNT), .Width(KW)) u_keys (
    .clk_i, .we_i(ky_we), .addr_i(ky_a), .wdata_i(ky_wd), .rdata_o(ky_rd));
  imh_mem #(.Depth(NODE_COUNT), .Width(2)) u_stat (
    .clk_i, .we_i(ns_we), .addr_i(ns_a), .wdata_i(ns_wd), .rdata_o(ns_rd));

  imh_key_cmp #(.KeyW(KEY_WIDTH)) u_cmp (.clk_i, .a_i(cmp_a), .b_i(cmp_b), .less_o(less));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= imh_pkg::S_IDLE;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      size_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      st_q      <= st_d;
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      size_q    <= size_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pos_q  <= pos_d;
    oth_q  <= oth_d;
    nid_q  <= nid_d;
    onid_q <= onid_d;
    lnid_q <= lnid_d;
    key_q  <= key_d;
    okey_q <= okey_d;
    lkey_q <= lkey_d;
    up_q   <= up_d;
    hasr_q <= hasr_d;
    swp_q  <= swp_d;
    rsp_q  <= rsp_d;
  end

  logic          id_ok;
  logic [AW-1:0] id_a;
  logic [KW-1:0] in_key;
  logic [CW-1:0] left_w;
  logic [AW-1:0] parent_w;

  always_comb begin
    id_ok  = ({{(32-IdW){1'b0}}, cmd_q.node_id} < NODE_COUNT);
    id_a   = AW'(cmd_q.node_id);
    in_key = {cmd_q.key_primary[KEY_WIDTH-1:0], cmd_q.key_secondary[KEY_WIDTH-1:0]};
    left_w = {pos_q, 1'b1};
    parent_w = AW'((pos_q - 1'b1) >> 1);
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; clr_cnt_d = clr_cnt_q;
    cmd_d = cmd_q; size_d = size_q; pos_d = pos_q; oth_d = oth_q;
    nid_d = nid_q; onid_d = onid_q; lnid_d = lnid_q;
    key_d = key_q; okey_d = okey_q; lkey_d = lkey_q;
    up_d = up_q; hasr_d = hasr_q; swp_d = swp_q; rsp_d = rsp_q; done_d = 1'b0;
    sl_we = 1'b0; ps_we = 1'b0; ky_we = 1'b0; ns_we = 1'b0;
    sl_a = pos_q; ps_a = nid_q; ky_a = nid_q; ns_a = id_a;
    sl_wd = nid_q; ps_wd = pos_q; ky_wd = in_key; ns_wd = imh_pkg::NODE_OPEN;
    cmp_a = key_q; cmp_b = okey_q;

    case (st_q)
      imh_pkg::S_IDLE: begin
        if (clr_q) begin
          ns_we = 1'b1; ns_a = clr_cnt_q; ns_wd = imh_pkg::NODE_UNSEEN;
          clr_cnt_d = clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(NODE_COUNT - 1)) clr_d = 1'b0;
        end else if (start) begin
          cmd_d = cmd_i;
          rsp_d = '0;
          rsp_d.status = imh_pkg::STAT_OK;
          st_d = (cmd_i.kind == imh_pkg::KIND_POP) ? imh_pkg::S_POP_RD : imh_pkg::S_CHK;
        end
      end
      imh_pkg::S_CHK: begin
        st_d = imh_pkg::S_CHK_W;   // status read issued (ns_a = id)
      end
      imh_pkg::S_CHK_W: begin
        nid_d = id_a; key_d = in_key;
        if (!id_ok) begin
          rsp_d.status = imh_pkg::STAT_NOT_OPEN; st_d = imh_pkg::S_TOP_RD;
        end else if (cmd_q.kind == imh_pkg::KIND_INSERT) begin
          if (ns_rd == imh_pkg::NODE_OPEN) begin
            rsp_d.status = imh_pkg::STAT_IGNORED; st_d = imh_pkg::S_TOP_RD;
          end else begin
            ns_we = 1'b1; ky_we = 1'b1; ky_a = id_a;
            pos_d = AW'(size_q); size_d = size_q + 1'b1;
            up_d = 1'b1; swp_d = 1'b0;
            st_d = imh_pkg::S_UPD_WR;
          end
        end else if (ns_rd != imh_pkg::NODE_OPEN) begin
          rsp_d.status = imh_pkg::STAT_NOT_OPEN; st_d = imh_pkg::S_TOP_RD;
        end else begin
          ps_a = id_a;
          st_d = imh_pkg::S_POS_RD;
        end
      end
      imh_pkg::S_POS_RD: begin
        st_d = imh_pkg::S_RM_RD;   // wait for position
        oth_d = '0;
      end
      imh_pkg::S_RM_RD: begin
        pos_d = ps_rd;
        if (cmd_q.kind == imh_pkg::KIND_UPDATE) begin
          ky_we = 1'b1; ky_a = nid_q;
          up_d = 1'b0; st_d = imh_pkg::S_UPD_WR;
        end else begin
          sl_a = AW'(size_q - 1'b1);
          st_d = imh_pkg::S_RM_WR;
        end
      end
      imh_pkg::S_POP_RD: begin
        if (size_q == '0) begin
          rsp_d.status = imh_pkg::STAT_EMPTY; st_d = imh_pkg::S_TOP_RD;
        end else begin
          sl_a = '0; pos_d = '0; st_d = imh_pkg::S_POP_K;
        end
      end
      imh_pkg::S_POP_K: begin
        if (!swp_q) begin
          nid_d = sl_rd; ky_a = sl_rd; swp_d = 1'b1;
        end else begin
          rsp_d.popped_node = IdW'(nid_q);
          rsp_d.popped_key_primary = 32'(ky_rd[KW-1:KEY_WIDTH]);
          rsp_d.popped_key_secondary = 32'(ky_rd[KEY_WIDTH-1:0]);
          sl_a = AW'(size_q - 1'b1);
          swp_d = 1'b0; st_d = imh_pkg::S_RM_WR;
        end
      end
      imh_pkg::S_RM_WR: begin
        // close removed node; sl_rd holds last slot's node
        ns_we = 1'b1; ns_a = nid_q; ns_wd = imh_pkg::NODE_CLOSED;
        size_d = size_q - 1'b1;
        if ({1'b0, pos_q} == size_q - 1'b1) begin
          st_d = imh_pkg::S_TOP_RD;
        end else begin
          nid_d = sl_rd; up_d = 1'b0;
          st_d = imh_pkg::S_UPD_WR;
        end
      end
      imh_pkg::S_UPD_WR: begin
        // place node nid at pos, then fetch its key
        sl_we = 1'b1; sl_a = pos_q; sl_wd = nid_q;
        ps_we = 1'b1; ps_a = nid_q; ps_wd = pos_q;
        if (!swp_q) begin
          swp_d = 1'b1; st_d = imh_pkg::S_UPD_WR;
          sl_we = 1'b1; ky_a = nid_q;
        end else begin
          swp_d = 1'b0; key_d = ky_rd;
          st_d = (pos_q == '0) ? imh_pkg::S_SD_RDL : imh_pkg::S_RP_RDP;
        end
      end
      imh_pkg::S_RP_RDP: begin
        sl_a = parent_w; oth_d = parent_w; st_d = imh_pkg::S_RP_RDK;
      end
      imh_pkg::S_RP_RDK: begin
        if (!swp_q) begin
          swp_d = 1'b1; onid_d = sl_rd; ky_a = sl_rd;
        end else begin
          swp_d = 1'b0; okey_d = ky_rd; st_d = imh_pkg::S_RP_CMP;
        end
      end
      imh_pkg::S_RP_CMP: begin
        if (!swp_q) begin
          swp_d = 1'b1;
        end else begin
          swp_d = 1'b0;
          if (less) begin
            up_d = 1'b1; st_d = imh_pkg::S_SWAP;
          end else if (up_q) begin
            st_d = imh_pkg::S_TOP_RD;
          end else begin
            st_d = imh_pkg::S_SD_RDL;
          end
        end
      end
      imh_pkg::S_SD_RDL: begin
        if (left_w >= size_q) begin
          st_d = imh_pkg::S_TOP_RD;
        end else begin
          sl_a = AW'(left_w);
          hasr_d = (left_w + 1'b1 < size_q);
          st_d = imh_pkg::S_SD_RDR;
        end
      end
      imh_pkg::S_SD_RDR: begin
        lnid_d = sl_rd; ky_a = sl_rd;
        sl_a = AW'(left_w + 1'b1);
        st_d = imh_pkg::S_SD_KL;
      end
      imh_pkg::S_SD_KL: begin
        lkey_d = ky_rd; onid_d = sl_rd; ky_a = sl_rd;
        st_d = hasr_q ? imh_pkg::S_SD_KR : imh_pkg::S_SD_SEL;
        if (!hasr_q) begin
          onid_d = lnid_q; okey_d = ky_rd; oth_d = AW'(left_w);
        end
      end
      imh_pkg::S_SD_KR: begin
        if (!swp_q) begin
          okey_d = ky_rd; swp_d = 1'b1;
        end else if (!hasr_q) begin
          swp_d = 1'b0; st_d = imh_pkg::S_SD_SEL; hasr_d = 1'b1;
        end
        cmp_a = lkey_q; cmp_b = okey_q;
        if (swp_q && hasr_q) begin
          hasr_d = 1'b0;  // wait for the registered compare
        end
      end
      imh_pkg::S_SD_SEL: begin
        if (hasr_q && !swp_q) begin
          oth_d = AW'(left_w + 1'b1);
          if (less) begin
            onid_d = lnid_q; okey_d = lkey_q; oth_d = AW'(left_w);
          end
          swp_d = 1'b1;
        end else if (!swp_q || hasr_q) begin
          swp_d = 1'b1; hasr_d = 1'b0;
        end else begin
          // compare child against node at pos: less is (key_child < key_pos)
          hasr_d = 1'b1;
          swp_d = 1'b0;
          st_d = imh_pkg::S_DONE;
        end
        cmp_a = okey_q; cmp_b = key_q;
      end
      imh_pkg::S_DONE: begin
        // sift-down decision
        if (hasr_q) begin
          hasr_d = 1'b0;
        end else if (less) begin
          st_d = imh_pkg::S_SWAP;
        end else begin
          st_d = imh_pkg::S_TOP_RD;
        end
        cmp_a = okey_q; cmp_b = key_q;
      end
      imh_pkg::S_SWAP: begin
        // node nid moves to oth, node onid moves to pos
        if (!swp_q) begin
          sl_we = 1'b1; sl_a = oth_q; sl_wd = nid_q;
          ps_we = 1'b1; ps_a = nid_q; ps_wd = oth_q;
          swp_d = 1'b1;
        end else begin
          sl_we = 1'b1; sl_a = pos_q; sl_wd = onid_q;
          ps_we = 1'b1; ps_a = onid_q; ps_wd = pos_q;
          swp_d = 1'b0; pos_d = oth_q;
          if (up_q) st_d = (oth_q == '0) ? imh_pkg::S_TOP_RD : imh_pkg::S_RP_RDP;
          else      st_d = imh_pkg::S_SD_RDL;
        end
      end
      imh_pkg::S_TOP_RD: begin
        sl_a = '0; swp_d = 1'b0; st_d = imh_pkg::S_TOP_W;
      end
      imh_pkg::S_TOP_W: begin
        rsp_d.top_valid = (size_q != '0);
        rsp_d.top_node = (size_q != '0) ? IdW'(sl_rd) : '0;
        rsp_d.entry_count = imh_pkg::CountWidth'(size_q);
        done_d = 1'b1; st_d = imh_pkg::S_IDLE;
      end
      default: st_d = imh_pkg::S_IDLE;
    endcase
  end

  assign busy   = (st_q != imh_pkg::S_IDLE) || clr_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command must raise busy")
  `ASSERT_IMPL(a_size_range, size_q <= CW'(NODE_COUNT), "heap size above node count")
  `ASSERT_NEXT(a_done_idle, done_o, !done_o, "result strobe longer than one cycle")
endmodule
